// ===== hdl/ecu_pkg.sv =====
// Package for the easing curve unit: curve codes and fixed widths.
// No dependencies.
`timescale 1ns / 1ps

package ecu_pkg;

    typedef enum logic [3:0] {
        OP_LINEAR   = 4'd0,
        OP_QUAD_IN  = 4'd1,
        OP_QUAD_OUT = 4'd2,
        OP_QUAD_IO  = 4'd3,
        OP_CUBE_IN  = 4'd4,
        OP_CUBE_OUT = 4'd5,
        OP_CUBE_IO  = 4'd6,
        OP_CIRC_IN  = 4'd7,
        OP_CIRC_OUT = 4'd8,
        OP_CIRC_IO  = 4'd9
    } t_op;

    localparam int unsigned OP_W  = 4;
    localparam int unsigned VAL_W = 32;

endpackage

// ===== hdl/ecu_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface ecu_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/ecu_div.sv =====
// Pipelined restoring divider: one quotient bit per stage.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module ecu_div #(
    parameter int unsigned TIME_BITS = 16,
    parameter int unsigned FRAC_BITS = 16,
    parameter int unsigned SIDE_W    = 70
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [TIME_BITS-1:0] i_num,
    input  logic [TIME_BITS-1:0] i_den,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic [FRAC_BITS:0]   o_quot,
    output logic [SIDE_W-1:0]    o_side
);
    // quotient of (num << FRAC_BITS)/den, num <= den so it fits FRAC_BITS+1 bits
    localparam int unsigned NS = FRAC_BITS + 1;
    localparam int unsigned RW = TIME_BITS + 1;

    logic [RW-1:0]        r_rem  [NS+1];
    logic [TIME_BITS-1:0] r_den  [NS+1];
    logic [FRAC_BITS:0]   r_q    [NS+1];
    logic [SIDE_W-1:0]    r_side [NS+1];
    logic                 r_v    [NS+1];

    always_comb begin
        r_rem[0]  = {1'b0, i_num};
        r_den[0]  = i_den;
        r_q[0]    = '0;
        r_side[0] = i_side;
        r_v[0]    = i_valid;
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [RW-1:0] w_trial;
        logic [RW-1:0] w_rem;
        logic          w_bit;
        always_comb begin
            // first stage: remainder is num itself (quotient bit FRAC_BITS)
            if (s == 0) w_trial = r_rem[s];
            else        w_trial = {r_rem[s][RW-2:0], 1'b0};
            w_bit = (w_trial >= {1'b0, r_den[s]});
            w_rem = w_bit ? (w_trial - {1'b0, r_den[s]}) : w_trial;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
            if (i_en) begin
                r_rem[s+1]  <= w_rem;
                r_den[s+1]  <= r_den[s];
                r_q[s+1]    <= {r_q[s][FRAC_BITS-1:0], w_bit};
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_valid = r_v[NS];
    assign o_quot  = r_q[NS];
    assign o_side  = r_side[NS];
endmodule

// ===== hdl/ecu_sqrt.sv =====
// Pipelined integer square root: one result bit per stage.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module ecu_sqrt #(
    parameter int unsigned RB     = 17,
    parameter int unsigned SIDE_W = 70
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*RB-1:0]   i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [RB-1:0]     o_root,
    output logic [SIDE_W-1:0] o_side
);
    localparam int unsigned NW = 2 * RB;
    localparam int unsigned TW = RB + 2;

    logic [NW-1:0]     r_n    [RB+1];
    logic [TW-1:0]     r_rem  [RB+1];
    logic [RB-1:0]     r_root [RB+1];
    logic [SIDE_W-1:0] r_side [RB+1];
    logic              r_v    [RB+1];

    always_comb begin
        r_n[0]    = i_rad;
        r_rem[0]  = '0;
        r_root[0] = '0;
        r_side[0] = i_side;
        r_v[0]    = i_valid;
    end

    for (genvar s = 0; s < RB; s++) begin : g_stage
        logic [TW-1:0] w_cur;
        logic [TW-1:0] w_try;
        logic          w_ok;
        always_comb begin
            // bring down two radicand bits, try root*4+1
            w_cur = {r_rem[s][TW-3:0], r_n[s][NW-1 -: 2]};
            w_try = {r_root[s], 2'b01};
            w_ok  = (w_cur >= w_try);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
            if (i_en) begin
                r_n[s+1]    <= {r_n[s][NW-3:0], 2'b00};
                r_rem[s+1]  <= w_ok ? (w_cur - w_try) : w_cur;
                r_root[s+1] <= {r_root[s][RB-2:0], w_ok};
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_valid = r_v[RB];
    assign o_root  = r_root[RB];
    assign o_side  = r_side[RB];
endmodule

// ===== hdl/easing_curve_unit_core.sv =====
// Top level of the easing curve unit: divider, curve, root and scale pipeline.
// Depends on ecu_pkg, ecu_if, ecu_div and ecu_sqrt.
`timescale 1ns / 1ps

// Easing curve unit.
// The input channel carries one word per evaluation: curve code, elapsed
// time, duration, start value and change. The output channel returns one
// word per input: the eased value b + c*f(t/d), saturated to 32 bits, and
// an error bit for zero duration or an unknown code (value is then b).
// Throughput is one word per cycle while the receiver keeps ready high.
// The pipeline is (FRAC_BITS+1) divider stages + 3 curve stages +
// (FRAC_BITS+1) root stages + 2 scale stages; the divider and root stage
// counts are set by the bit-serial divider and square-root pipelines.
// All words pass through the root pipeline so order is kept.
// The whole pipeline advances together; when the receiver holds ready low
// with a word waiting, every stage holds and input ready drops. Nothing is
// lost or repeated. Reset clears all valid bits; payload is not reset.
module easing_curve_unit_core #(
    parameter int unsigned TIME_BITS = 16,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ecu_if.sink   i_in,
    ecu_if.source o_out
);
    localparam int unsigned QW  = FRAC_BITS + 1;
    localparam int unsigned PW  = 2 * QW;
    localparam int unsigned SW  = ecu_pkg::OP_W + 2 + 2 * ecu_pkg::VAL_W;
    localparam logic [QW-1:0] ONE_Q  = QW'(1) << FRAC_BITS;
    localparam logic [QW-1:0] HALF_Q = QW'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic [ecu_pkg::OP_W-1:0]  op;
        logic                      err;
        logic                      spare;
        logic [ecu_pkg::VAL_W-1:0] b;
        logic [ecu_pkg::VAL_W-1:0] c;
    } t_side;

    logic w_en;
    logic w_outv;
    assign w_en       = !w_outv || o_out.ready;
    assign i_in.ready = w_en;

    // ---------------- divide
    logic [TIME_BITS-1:0] w_t, w_d;
    t_side w_s0;
    always_comb begin
        w_d = TIME_BITS'(i_in.data.duration);
        w_t = TIME_BITS'(i_in.data.elapsed);
        if (w_t > w_d) w_t = w_d;
        w_s0.op    = i_in.data.opcode;
        w_s0.err   = (w_d == '0) || (i_in.data.opcode > ecu_pkg::OP_W'(ecu_pkg::OP_CIRC_IO));
        w_s0.spare = 1'b0;
        w_s0.b     = i_in.data.start_value;
        w_s0.c     = i_in.data.change;
    end

    logic          w_dv;
    logic [QW-1:0] w_u;
    logic [SW-1:0] w_ds;
    ecu_div #(.TIME_BITS(TIME_BITS), .FRAC_BITS(FRAC_BITS), .SIDE_W(SW)) u_div (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(i_in.valid && i_in.ready),
        .i_num(w_t), .i_den(w_d), .i_side(w_s0),
        .o_valid(w_dv), .o_quot(w_u), .o_side(w_ds)
    );

    // ---------------- curve stage 1: pick operand, square
    t_side         w_sd;
    logic [QW-1:0] w_x;
    logic          w_lo;
    assign w_sd = t_side'(w_ds);
    assign w_lo = w_u < HALF_Q;
    always_comb begin
        case (w_sd.op)
            ecu_pkg::OP_QUAD_OUT, ecu_pkg::OP_CUBE_OUT, ecu_pkg::OP_CIRC_OUT:
                w_x = ONE_Q - w_u;
            ecu_pkg::OP_QUAD_IO, ecu_pkg::OP_CUBE_IO:
                w_x = w_lo ? w_u : ONE_Q - w_u;
            ecu_pkg::OP_CIRC_IO:
                w_x = w_lo ? QW'({w_u, 1'b0}) : QW'({ONE_Q - w_u, 1'b0});
            default:
                w_x = w_u;
        endcase
    end

    logic          r1_v, r1_lo;
    t_side         r1_s;
    logic [QW-1:0] r1_u, r1_x, r1_sq;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (w_en) r1_v <= w_dv;
        if (w_en) begin
            r1_s  <= w_sd;
            r1_u  <= w_u;
            r1_x  <= w_x;
            r1_lo <= w_lo;
            r1_sq <= QW'(({{QW{1'b0}}, w_x} * {{QW{1'b0}}, w_x}) >> FRAC_BITS);
        end
    end

    // ---------------- curve stage 2: cube
    logic          r2_v, r2_lo;
    t_side         r2_s;
    logic [QW-1:0] r2_u, r2_sq, r2_cb;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (w_en) r2_v <= r1_v;
        if (w_en) begin
            r2_s  <= r1_s;
            r2_u  <= r1_u;
            r2_lo <= r1_lo;
            r2_sq <= r1_sq;
            r2_cb <= QW'(({{QW{1'b0}}, r1_sq} * {{QW{1'b0}}, r1_x}) >> FRAC_BITS);
        end
    end

    // ---------------- curve stage 3: polynomial result and root radicand
    logic [QW+1:0] w_f;
    logic [QW-1:0] w_rad;
    always_comb begin
        w_rad = ONE_Q - r2_sq;
        case (r2_s.op)
            ecu_pkg::OP_QUAD_IN:  w_f = (QW+2)'(r2_sq);
            ecu_pkg::OP_QUAD_OUT: w_f = (QW+2)'(ONE_Q - r2_sq);
            ecu_pkg::OP_QUAD_IO:
                w_f = r2_lo ? (QW+2)'({r2_sq, 1'b0})
                            : (QW+2)'(ONE_Q) - (QW+2)'({r2_sq, 1'b0});
            ecu_pkg::OP_CUBE_IN:  w_f = (QW+2)'(r2_cb);
            ecu_pkg::OP_CUBE_OUT: w_f = (QW+2)'(ONE_Q - r2_cb);
            ecu_pkg::OP_CUBE_IO:
                w_f = r2_lo ? (QW+2)'({r2_cb, 2'b00})
                            : (QW+2)'(ONE_Q) - (QW+2)'({r2_cb, 2'b00});
            default:              w_f = (QW+2)'(r2_u);
        endcase
    end

    typedef struct packed {
        t_side         s;
        logic          lo;
        logic [QW+1:0] f;
    } t_rside;
    localparam int unsigned RSW = $bits(t_rside);

    logic          r3_v;
    t_rside        r3_rs;
    logic [QW-1:0] r3_rad;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (w_en) r3_v <= r2_v;
        if (w_en) begin
            r3_rs.s  <= r2_s;
            r3_rs.lo <= r2_lo;
            r3_rs.f  <= w_f;
            r3_rad   <= w_rad;
        end
    end

    logic           w_sv;
    logic [QW-1:0]  w_root;
    logic [RSW-1:0] w_so;
    ecu_sqrt #(.RB(QW), .SIDE_W(RSW)) u_sqrt (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r3_v),
        .i_rad({1'b0, r3_rad, {FRAC_BITS{1'b0}}}), .i_side(r3_rs),
        .o_valid(w_sv), .o_root(w_root), .o_side(w_so)
    );

    // ---------------- scale stage 1: final curve value, multiply by c
    t_rside        w_ro;
    logic [QW-1:0] w_fc;
    assign w_ro = t_rside'(w_so);
    always_comb begin
        case (w_ro.s.op)
            ecu_pkg::OP_CIRC_IN:  w_fc = ONE_Q - w_root;
            ecu_pkg::OP_CIRC_OUT: w_fc = w_root;
            ecu_pkg::OP_CIRC_IO:
                w_fc = w_ro.lo ? QW'((ONE_Q - w_root) >> 1)
                               : QW'(({1'b0, ONE_Q} + {1'b0, w_root}) >> 1);
            default:              w_fc = QW'(w_ro.f);
        endcase
    end

    localparam int unsigned MW = ecu_pkg::VAL_W + QW + 1;
    logic                    r4_v;
    t_side                   r4_s;
    logic signed [MW-1:0]    r4_p;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (w_en) r4_v <= w_sv;
        if (w_en) begin
            r4_s <= w_ro.s;
            r4_p <= MW'($signed(w_ro.s.c)) * MW'($signed({1'b0, w_fc}));
        end
    end

    // ---------------- scale stage 2: round toward minus infinity, add, saturate
    logic signed [MW-1:0] w_dl;
    logic signed [MW:0]   w_sum;
    logic signed [ecu_pkg::VAL_W-1:0] w_val;
    always_comb begin
        if (r4_p >= 0) w_dl = r4_p >>> FRAC_BITS;
        else           w_dl = -((-r4_p + MW'(ONE_Q) - MW'(1)) >>> FRAC_BITS);
        w_sum = (MW+1)'(w_dl) + (MW+1)'($signed(r4_s.b));
        if (w_sum > (MW+1)'(32'sh7FFF_FFFF))
            w_val = 32'sh7FFF_FFFF;
        else if (w_sum < (MW+1)'(32'sh8000_0000))
            w_val = 32'sh8000_0000;
        else
            w_val = ecu_pkg::VAL_W'(w_sum);
        if (r4_s.err) w_val = r4_s.b;
    end

    logic                      r5_v;
    logic [ecu_pkg::VAL_W-1:0] r5_val;
    logic                      r5_err;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (w_en) r5_v <= r4_v;
        if (w_en) begin
            r5_val <= w_val;
            r5_err <= r4_s.err;
        end
    end

    assign w_outv           = r5_v;
    assign o_out.valid      = r5_v;
    assign o_out.data.value = r5_val;
    assign o_out.data.error = r5_err;

    // ---------------- checks
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.data.value))
        else $error("output word changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input blocked with empty output");
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r4_v) && $stable(r3_v))
        else $error("pipeline moved during stall");
endmodule
